/* sv/ihsp_pkg.sv */
`default_nettype none

package ihsp_pkg;

    // Byte counter width
    localparam int POSITION_BITS = 32;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Stored header bytes and JPEG segment window
    localparam int HDR_LEN = 26;
    localparam int WIN_LEN = 12;

    // Offset of the last byte of the first JPEG window (segment starts at 2)
    localparam logic [POSITION_BITS-1:0] SEG_FIRST_END = POSITION_BITS'(2 + WIN_LEN - 1);
    // Position of the byte that brings the file to the full header length
    localparam logic [POSITION_BITS-1:0] HDR_LAST_POS = POSITION_BITS'(HDR_LEN - 1);

    // Format codes
    localparam logic [1:0] FMT_BMP  = 2'd0;
    localparam logic [1:0] FMT_JPEG = 2'd1;
    localparam logic [1:0] FMT_GIF  = 2'd2;
    localparam logic [1:0] FMT_PNG  = 2'd3;

    // Signature bytes
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_B   = 8'h42;
    localparam logic [7:0] BYTE_M   = 8'h4D;
    localparam logic [7:0] BYTE_G   = 8'h47;
    localparam logic [7:0] BYTE_I   = 8'h49;
    localparam logic [7:0] BYTE_F   = 8'h46;
    localparam logic [7:0] BYTE_P   = 8'h50;
    localparam logic [7:0] BYTE_N   = 8'h4E;
    localparam logic [7:0] BYTE_H   = 8'h48;
    localparam logic [7:0] BYTE_D   = 8'h44;
    localparam logic [7:0] BYTE_R   = 8'h52;
    localparam logic [7:0] BYTE_PNG0 = 8'h89;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_SUB = 8'h1A;

    // Header bytes as the scanner sees them once the current byte is in
    typedef struct packed {
        logic                       long_enough;
        logic [HDR_LEN-1:0][7:0]    hdr;
        logic [WIN_LEN-1:0][7:0]    win;
    } t_snap;

    // JPEG start-of-frame markers that carry the frame size
    function automatic logic is_sof(input logic [7:0] m);
        case (m) inside
            8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC9, 8'hCA, 8'hCB: is_sof = 1'b1;
            default:                                         is_sof = 1'b0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* sv/ihsp_scan.sv */
`default_nettype none

module ihsp_scan
    import ihsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output t_snap            o_snap
);

    logic [HDR_LEN-1:0][7:0]    r_hdr, n_hdr;
    logic [WIN_LEN-1:0][7:0]    r_hist, n_hist;
    logic [WIN_LEN-1:0][7:0]    r_win, n_win;
    logic [POSITION_BITS-1:0]   r_pos, n_pos;
    logic [POSITION_BITS-1:0]   r_seg_end, n_seg_end;
    logic                       r_active, n_active;
    logic                       hit;
    logic                       jpeg;
    logic                       stop;
    logic [POSITION_BITS:0]     seg_sum;

    // Store header bytes at their own offset, shift the history
    always_comb begin
        for (int k = 0; k < HDR_LEN; k++) begin
            n_hdr[k] = (r_pos == POSITION_BITS'(k)) ? i_byte : r_hdr[k];
        end
        n_hist = {i_byte, r_hist[WIN_LEN-1:1]};
    end

    // Walk JPEG segments: take the window when its last byte arrives
    always_comb begin
        hit     = r_active && (r_pos == r_seg_end);
        jpeg    = (r_hdr[0] == BYTE_FF) && (r_hdr[1] == BYTE_SOI);
        stop    = (n_hist[0] != BYTE_FF) || is_sof(n_hist[1]);
        seg_sum = {1'b0, r_seg_end} + (POSITION_BITS+1)'({n_hist[2], n_hist[3]})
                  + (POSITION_BITS+1)'(2);
        n_win     = (hit && jpeg) ? n_hist : r_win;
        n_active  = r_active;
        n_seg_end = r_seg_end;
        if (hit) begin
            if (!jpeg || stop) begin
                n_active = 1'b0;
            end else if (seg_sum >= {1'b0, POS_MAX}) begin
                // next window lies past the counter range: never completes
                n_active = 1'b0;
            end else begin
                n_seg_end = seg_sum[POSITION_BITS-1:0];
            end
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POSITION_BITS'(1);
    end

    // Advance control state; restart the walk after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_seg_end <= SEG_FIRST_END;
            r_active  <= 1'b1;
        end else if (i_step) begin
            if (i_last) begin
                r_pos     <= '0;
                r_seg_end <= SEG_FIRST_END;
                r_active  <= 1'b1;
            end else begin
                r_pos     <= n_pos;
                r_seg_end <= n_seg_end;
                r_active  <= n_active;
            end
        end
    end

    // Hold byte stores
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr  <= n_hdr;
            r_hist <= n_hist;
            r_win  <= n_win;
        end
    end

    assign o_snap = '{long_enough: (r_pos >= HDR_LAST_POS), hdr: n_hdr, win: n_win};

endmodule

`default_nettype wire

/* sv/ihsp_judge.sv */
`default_nettype none

module ihsp_judge
    import ihsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic               i_ready,
    input  wire t_snap              i_snap,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [1:0]              o_format,
    output logic signed [31:0]      o_width,
    output logic signed [31:0]      o_height
);

    logic                       r_valid;
    logic                       r_found, n_found;
    logic [1:0]                 r_format, n_format;
    logic [31:0]                r_width, n_width;
    logic [31:0]                r_height, n_height;
    logic [HDR_LEN-1:0][7:0]    h;
    logic [WIN_LEN-1:0][7:0]    w;

    assign h = i_snap.hdr;
    assign w = i_snap.win;

    // Check formats in priority order
    always_comb begin
        n_found  = 1'b0;
        n_format = FMT_BMP;
        n_width  = '0;
        n_height = '0;
        if (!i_snap.long_enough) begin
            n_found = 1'b0;
        end else if (h[0] == BYTE_B && h[1] == BYTE_M) begin
            n_found  = 1'b1;
            n_format = FMT_BMP;
            n_width  = {h[21], h[20], h[19], h[18]};
            n_height = {h[25], h[24], h[23], h[22]};
        end else if (h[0] == BYTE_FF && h[1] == BYTE_SOI && w[0] == BYTE_FF) begin
            n_found  = 1'b1;
            n_format = FMT_JPEG;
            n_height = {16'h0000, w[5], w[6]};
            n_width  = {16'h0000, w[7], w[8]};
        end else if (h[0] == BYTE_G && h[1] == BYTE_I && h[2] == BYTE_F) begin
            n_found  = 1'b1;
            n_format = FMT_GIF;
            n_width  = {16'h0000, h[7], h[6]};
            n_height = {16'h0000, h[9], h[8]};
        end else if (h[0] == BYTE_PNG0 && h[1] == BYTE_P && h[2] == BYTE_N
                     && h[3] == BYTE_G && h[4] == BYTE_CR && h[5] == BYTE_LF
                     && h[6] == BYTE_SUB && h[7] == BYTE_LF
                     && h[12] == BYTE_I && h[13] == BYTE_H
                     && h[14] == BYTE_D && h[15] == BYTE_R) begin
            n_found  = 1'b1;
            n_format = FMT_PNG;
            n_width  = {h[16], h[17], h[18], h[19]};
            n_height = {h[20], h[21], h[22], h[23]};
        end
    end

    // Hold the result until the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_found  <= n_found;
            r_format <= n_format;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_valid  = r_valid;
    assign o_found  = r_found;
    assign o_format = r_format;
    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

`default_nettype wire

/* sv/image_header_size_parser.sv */
`default_nettype none

// Image size sniffer: feed an image file one byte per request in file order and
// mark its final byte with i_last_byte. For that final byte one result follows
// with o_found, o_format (0 BMP, 1 JPEG, 2 GIF, 3 PNG) and the width and height
// as raw 32-bit values from the header; files shorter than 26 bytes report not
// found with zero fields. Other bytes give no result. One byte is taken every
// clock cycle; a byte is held in the input register, and a final byte's result
// is then registered in the result register. The rate is set by the per-byte
// segment-walk update (one 33-bit add and compare); input stalls only while a
// finished result waits and another final byte is pending. After each final
// byte the block starts a new file.
module image_header_size_parser
    import ihsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_found,
    output logic [1:0]              o_format,
    output logic signed [31:0]      o_width,
    output logic signed [31:0]      o_height
);

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_last;
    logic           out_free;
    logic           adv;
    t_snap          snap;

    // Advance a held byte unless its result cannot be stored
    assign out_free = !o_valid || i_ready;
    assign adv      = r_in_valid && (!r_in_last || out_free);
    assign o_ready  = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ihsp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_snap  (snap)
    );

    ihsp_judge u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && r_in_last),
        .i_ready  (i_ready),
        .i_snap   (snap),
        .o_valid  (o_valid),
        .o_found  (o_found),
        .o_format (o_format),
        .o_width  (o_width),
        .o_height (o_height)
    );

endmodule

`default_nettype wire

/* sv/ihsp_checker.sv */
`default_nettype none

module ihsp_checker
    import ihsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               o_ready,
    input  wire logic               o_valid,
    input  wire logic               i_ready,
    input  wire logic               o_found,
    input  wire logic [1:0]         o_format,
    input  wire logic signed [31:0] o_width,
    input  wire logic signed [31:0] o_height
);

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_format))
        else $error("stalled result changed");

    // An unrecognized file reports zero fields
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_format == FMT_BMP && o_width == 0 && o_height == 0)
        else $error("not-found result carries data");

    // Input never stalls while the output side is empty
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

bind image_header_size_parser ihsp_checker u_ihsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_found  (o_found),
    .o_format (o_format),
    .o_width  (o_width),
    .o_height (o_height)
);

`default_nettype wire
